>>> rtl/fir128_pkg.sv
// Shared constants, coefficient table and types for the 128-tap FIR filter.
`timescale 1ns / 1ps

package fir128_pkg;

    localparam int TAPS_DEF        = 128;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEFF_BITS      = 16;
    localparam int ACC_BITS        = 40;
    localparam int HALF_LEN        = 64;
    localparam int FULL_LEN        = 128;

    // First half of the symmetric table, Q1.15; tap i equals tap 127-i.
    localparam logic signed [COEFF_BITS-1:0] HALF_COEFF [HALF_LEN] = '{
           16'sd6,    -16'sd5,   -16'sd11,   -16'sd21,
          -16'sd35,   -16'sd55,   -16'sd80,  -16'sd113,
         -16'sd152,  -16'sd198,  -16'sd251,  -16'sd309,
         -16'sd372,  -16'sd437,  -16'sd502,  -16'sd564,
         -16'sd621,  -16'sd669,  -16'sd705,  -16'sd726,
         -16'sd730,  -16'sd715,  -16'sd679,  -16'sd621,
         -16'sd544,  -16'sd449,  -16'sd338,  -16'sd215,
          -16'sd87,    16'sd43,   16'sd167,   16'sd279,
          16'sd374,   16'sd445,   16'sd489,   16'sd501,
          16'sd481,   16'sd428,   16'sd345,   16'sd234,
          16'sd103,   -16'sd42,  -16'sd193,  -16'sd338,
         -16'sd469,  -16'sd574,  -16'sd646,  -16'sd675,
         -16'sd655,  -16'sd582,  -16'sd454,  -16'sd272,
          -16'sd40,   16'sd237,   16'sd549,   16'sd885,
         16'sd1233,  16'sd1579,  16'sd1908,  16'sd2208,
         16'sd2465,  16'sd2668,  16'sd2809,  16'sd2881
    };

    // Coefficient of a tap; taps past the designed length are zero.
    function automatic logic signed [COEFF_BITS-1:0] coeff_at(input logic [31:0] tap);
        logic [5:0] idx;
        logic [31:0] mirror;
        mirror = 32'(FULL_LEN - 1) - tap;
        if (tap < 32'(HALF_LEN)) begin
            idx = tap[5:0];
            return HALF_COEFF[idx];
        end else if (tap < 32'(FULL_LEN)) begin
            idx = mirror[5:0];
            return HALF_COEFF[idx];
        end else begin
            return '0;
        end
    endfunction

    // One tap issued by the sequencer toward the MAC datapath.
    typedef struct packed {
        logic                         valid;
        logic                         first;
        logic                         last;
        logic                         live;   // entry holds a written sample
        logic signed [COEFF_BITS-1:0] coeff;
    } tap_issue_t;

endpackage

>>> rtl/fir128_mem.sv
// Delay-line sample memory: one write port, one registered read port.
`timescale 1ns / 1ps

module fir128_mem #(
    parameter int DEPTH = fir128_pkg::TAPS_DEF,
    parameter int WIDTH = fir128_pkg::SAMPLE_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/fir128_mac.sv
// Multiply-accumulate datapath, output truncation/saturation and result register.
`timescale 1ns / 1ps

module fir128_mac #(
    parameter int SAMPLE_BITS = fir128_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fir128_pkg::tap_issue_t        issue,
    input  logic [SAMPLE_BITS-1:0]        rd_data,
    output logic                          busy,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_filtered
);

    localparam int PW  = SAMPLE_BITS + fir128_pkg::COEFF_BITS;
    localparam int AB  = fir128_pkg::ACC_BITS;
    localparam int EW  = (PW > AB) ? PW : AB;
    localparam int SH  = fir128_pkg::COEFF_BITS - 1;
    localparam int QW  = AB - SH;
    localparam int CW  = ((QW > SAMPLE_BITS) ? QW : SAMPLE_BITS) + 1;
    localparam logic signed [CW-1:0] OUT_HI = CW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [CW-1:0] OUT_LO = -OUT_HI - CW'(1);

    fir128_pkg::tap_issue_t s1_reg;

    logic signed [PW-1:0] prod_reg, prod_next;
    logic                 s2_valid_reg, s2_first_reg, s2_last_reg;

    logic signed [AB-1:0] acc_reg, acc_next;
    logic signed [EW-1:0] prod_ext;
    logic                 pend_reg;

    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg, out_next;
    logic signed [QW-1:0]          q;
    logic signed [CW-1:0]          q_ext;
    logic                          load_out;

    // Stage 1: issue info aligned with the registered memory read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
        end else begin
            s1_reg <= issue;
        end
    end

    // Stage 2: product; entries never written count as zero
    always_comb begin
        if (s1_reg.live) begin
            prod_next = $signed(rd_data) * $signed(s1_reg.coeff);
        end else begin
            prod_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end else begin
            s2_valid_reg <= s1_reg.valid;
            s2_first_reg <= s1_reg.first;
            s2_last_reg  <= s1_reg.last;
        end
        prod_reg <= prod_next;
    end

    // Stage 3: accumulate, wrapping at the accumulator width
    assign prod_ext = EW'(prod_reg);
    assign acc_next = s2_first_reg ? prod_ext[AB-1:0] : acc_reg + prod_ext[AB-1:0];

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    // Floor back to Q1.15, then clamp
    assign q     = QW'(acc_reg >>> SH);
    assign q_ext = CW'(q);

    always_comb begin
        priority if (q_ext > OUT_HI) begin
            out_next = OUT_HI[SAMPLE_BITS-1:0];
        end else if (q_ext < OUT_LO) begin
            out_next = OUT_LO[SAMPLE_BITS-1:0];
        end else begin
            out_next = q_ext[SAMPLE_BITS-1:0];
        end
    end

    assign load_out = pend_reg && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s2_valid_reg && s2_last_reg) begin
                pend_reg <= 1'b1;
            end else if (load_out) begin
                pend_reg <= 1'b0;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    assign busy       = s1_reg.valid || s2_valid_reg || pend_reg;
    assign m_valid    = m_valid_reg;
    assign m_filtered = out_reg;

endmodule

>>> rtl/fir_filter_128_tap.sv
// Top level of the 128-tap direct-form FIR filter with a shared MAC.
// A new item is taken only once the MAC has drained the last one; one delay-line memory read per tap.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) empties the delay line via a fill count.
`timescale 1ns / 1ps

module fir_filter_128_tap #(
    parameter int TAPS        = fir128_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = fir128_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_filtered
);

    localparam int AW = $clog2(TAPS);
    localparam int FW = $clog2(TAPS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);
    localparam logic [FW-1:0] FILL_MAX  = FW'(TAPS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] age_reg, age_next;
    logic [FW-1:0] fill_reg, fill_next;

    logic                   accept;
    logic                   mac_busy;
    logic [SAMPLE_BITS-1:0] rd_data;
    fir128_pkg::tap_issue_t issue;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next  = state_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        age_next    = age_reg;
        fill_next   = fill_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + AW'(1);
                    rd_ptr_next = wr_ptr_reg;
                    age_next    = '0;
                    fill_next   = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + FW'(1);
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                // walk from newest to oldest sample
                rd_ptr_next = (rd_ptr_reg == '0) ? LAST_ADDR : rd_ptr_reg - AW'(1);
                age_next    = age_reg + AW'(1);
                if (age_reg == LAST_ADDR) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!mac_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
            rd_ptr_reg <= '0;
            age_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
            rd_ptr_reg <= rd_ptr_next;
            age_reg    <= age_next;
        end
    end

    always_comb begin
        issue.valid = (state_reg == ST_RUN);
        issue.first = (age_reg == '0);
        issue.last  = (age_reg == LAST_ADDR);
        issue.live  = (FW'(age_reg) < fill_reg);
        issue.coeff = fir128_pkg::coeff_at(32'(age_reg));
    end

    fir128_mem #(
        .DEPTH (TAPS),
        .WIDTH (SAMPLE_BITS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (wr_ptr_reg),
        .wr_data (s_sample),
        .rd_en   (issue.valid),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    fir128_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .issue      (issue),
        .rd_data    (rd_data),
        .busy       (mac_busy),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered)
    );

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("fill count above tap count");

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mac_busy)
        else $error("new item taken while MAC still busy");

    a_run_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && age_reg == LAST_ADDR) |=> (state_reg == ST_WAIT))
        else $error("tap sweep did not end after the last tap");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_RUN && age_reg == '0 && rd_ptr_reg == $past(wr_ptr_reg)))
        else $error("tap sweep did not start at the newest sample");

endmodule

>>> tb/fir_filter_128_tap_checker.sv
// Checker for the 128-tap FIR filter: tracks the delay line and compares each output item.
`timescale 1ns / 1ps

module fir_filter_128_tap_checker (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_valid,
    input  logic                                          s_ready,
    input  logic signed [fir128_pkg::SAMPLE_BITS_DEF-1:0] s_sample,
    input  logic                                          m_valid,
    input  logic                                          m_ready,
    input  logic signed [fir128_pkg::SAMPLE_BITS_DEF-1:0] m_filtered,
    output int                                            fail_count,
    output int                                            pending
);

    localparam int SW   = fir128_pkg::SAMPLE_BITS_DEF;
    localparam int CB   = fir128_pkg::COEFF_BITS;
    localparam int AB   = fir128_pkg::ACC_BITS;
    localparam int NTAP = fir128_pkg::TAPS_DEF;

    localparam logic signed [AB-1:0] OUT_MAX = (AB'(1) <<< (SW - 1)) - 1;
    localparam logic signed [AB-1:0] OUT_MIN = -OUT_MAX - 1;

    logic signed [SW-1:0] history [NTAP];
    logic signed [SW-1:0] filtered_q [$];
    int errors = 0;

    // Shift the new sample in at tap 0, then run the full MAC, floor to Q1.15 and clamp.
    function automatic logic signed [SW-1:0] shift_and_filter(
        input logic signed [SW-1:0] x
    );
        logic signed [AB-1:0]    acc;
        logic signed [AB-1:0]    q;
        logic signed [SW+CB-1:0] prod;
        logic signed [CB-1:0]    c;
        for (int i = NTAP - 1; i > 0; i--) history[i] = history[i-1];
        history[0] = x;
        acc = '0;
        for (int i = 0; i < NTAP; i++) begin
            // symmetric table, only the first half is stored
            if (i < fir128_pkg::HALF_LEN) begin
                c = fir128_pkg::HALF_COEFF[i];
            end else if (i < fir128_pkg::FULL_LEN) begin
                c = fir128_pkg::HALF_COEFF[fir128_pkg::FULL_LEN - 1 - i];
            end else begin
                c = '0;
            end
            prod = history[i] * c;
            acc  = acc + prod;
        end
        q = acc >>> (CB - 1);
        if (q > OUT_MAX) q = OUT_MAX;
        if (q < OUT_MIN) q = OUT_MIN;
        return q[SW-1:0];
    endfunction

    always @(posedge aclk) begin
        logic signed [SW-1:0] want;
        if (!aresetn) begin
            foreach (history[i]) history[i] = '0;
            filtered_q.delete();
        end else begin
            if (s_valid && s_ready) filtered_q.push_back(shift_and_filter(s_sample));
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    errors++;
                    $display("%0t: filtered item with none pending: expected none, got %0d",
                             $time, m_filtered);
                end else begin
                    want = filtered_q.pop_front();
                    if (m_filtered !== want) begin
                        errors++;
                        $display("%0t: filtered mismatch: expected %0d, got %0d",
                                 $time, want, m_filtered);
                    end
                end
            end
        end
        pending    <= filtered_q.size();
        fail_count <= errors;
    end

endmodule

>>> tb/fir_filter_128_tap_test.sv
// Top of the 128-tap FIR filter testbench: clock, reset, stimulus, ready pattern and verdict.
`timescale 1ns / 1ps

module fir_filter_128_tap_test;

    localparam int SW           = fir128_pkg::SAMPLE_BITS_DEF;
    localparam int HALF_LEN     = fir128_pkg::HALF_LEN;
    localparam int FULL_LEN     = fir128_pkg::FULL_LEN;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = fir128_pkg::TAPS_DEF + 5 + 16;
    localparam int NUM_CORNERS  = 20;

    localparam logic signed [SW-1:0] CORNER_SAMPLES [NUM_CORNERS] = '{
        16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000,
        16'sh0000, 16'shffff, 16'sh0001, 16'sh7fff, 16'sh8000,
        16'sh7fff, 16'sh8000, 16'sh5555, 16'shaaaa, 16'sh4000,
        16'shc000, 16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh8000
    };

    logic                 aclk       = 1'b0;
    logic                 aresetn    = 1'b0;
    logic                 s_valid    = 1'b0;
    logic                 s_ready;
    logic signed [SW-1:0] s_sample   = '0;
    logic                 m_valid;
    logic                 m_ready    = 1'b0;
    logic signed [SW-1:0] m_filtered;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stuck_cycles   = 0;
    int fail_count;
    int pending;

    fir_filter_128_tap u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered)
    );

    fir_filter_128_tap_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Ends the run if neither channel moves an item for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("fir_filter_128_tap_test: FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_sample(input logic signed [SW-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Noise, low-level signal, then a burst that matches the tap signs to drive
    // the output into saturation (polarity picks the rail).
    task automatic run_phase(input int snd_pct, input int rcv_pct, input bit neg_rail);
        logic signed [SW-1:0] v;
        int                   mag;
        int                   idx;
        bit                   flip;
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        for (int k = 0; k < 30; k++) begin
            send_sample(SW'($urandom));
        end
        for (int k = 0; k < 20; k++) begin
            v = SW'($urandom_range(511)) - 16'sd256;
            send_sample(v);
        end
        for (int k = 0; k < FULL_LEN; k++) begin
            idx  = (k < HALF_LEN) ? k : FULL_LEN - 1 - k;
            mag  = (k % 16 == 0) ? 32767 : $urandom_range(32767, 28000);
            flip = (fir128_pkg::HALF_COEFF[idx] < 0) != neg_rail;
            v    = flip ? ~SW'(mag) : SW'(mag);
            send_sample(v);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = 0; k < NUM_CORNERS; k++) send_sample(CORNER_SAMPLES[k]);

        run_phase(0, 0, 1'b0);
        run_phase(51, 0, 1'b1);
        run_phase(0, 51, 1'b0);
        run_phase(37, 37, 1'b1);

        s_valid <= 1'b0;
        // let the count of the last item settle before waiting on it
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("fir_filter_128_tap_test: PASS");
        end else begin
            $display("fir_filter_128_tap_test: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/fir128_pkg.sv
rtl/fir128_mem.sv
rtl/fir128_mac.sv
rtl/fir_filter_128_tap.sv
tb/fir_filter_128_tap_checker.sv
tb/fir_filter_128_tap_test.sv
